### rtl/wmog_pkg.sv
// Shared types, constants and waveform helpers of the waveform motion offset generator.
// Holds the quarter-wave sine table, built at elaboration. Depends on nothing.
package wmog_pkg;

    // Phase accumulator width and sine table resolution.
    localparam int PHASE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int SIDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int QR_W     = PHASE_BITS - 2;
    localparam int STEP_SHR = (PHASE_BITS <= 24) ? 24 - PHASE_BITS : 0;
    localparam int STEP_SHL = (PHASE_BITS > 24) ? PHASE_BITS - 24 : 0;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP  = 2'd2;
    localparam logic [15:0] FREQ_RESET = 16'd256;

    // Arithmetic constants.
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [15:0] DIVE_MIN_FREQ = 16'd64;
    localparam logic [16:0] CIRCLE_SCALE  = 17'd39322;
    localparam logic [16:0] UNIT_SCALE    = 17'd65536;
    localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Pattern classes.
    typedef enum logic [2:0] {
        PAT_LINEAR = 3'd0,
        PAT_SINE   = 3'd1,
        PAT_ZIGZAG = 3'd2,
        PAT_DIVE   = 3'd3,
        PAT_CIRCLE = 3'd4
    } t_pat;

    typedef struct packed {
        logic [2:0]  pattern_mode;
        logic [15:0] wave_frequency;
        logic [15:0] wave_amplitude;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        tick_time;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] anchor_y;
    } t_out_item;

    typedef struct packed {
        t_in_item item;
        t_pat     pat;
    } t_q_entry;

    // Write side of the queue.
    typedef struct packed {
        logic     push;
        t_q_entry entry;
    } t_q_wr;

    // Read side of the queue.
    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_rd;

    // Signed waveform sample as sign and magnitude (Q1.16).
    typedef struct packed {
        logic        neg;
        logic [16:0] mag;
    } t_wave;

    typedef logic [16:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    // Two Taylor multiplications by x in Q30, truncating.
    function automatic logic [63:0] sq30(logic [63:0] term, logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Quarter-wave sine table, Q1.16, evaluated once at elaboration.
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            term = x;
            sum  = x;
            term = sq30(term, x) / 64'd6;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = sq30(term, x) / 64'd20;
            sum  = sum + term;
            term = sq30(term, x) / 64'd42;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = sq30(term, x) / 64'd72;
            sum  = sum + term;
            term = sq30(term, x) / 64'd110;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = sq30(term, x) / 64'd156;
            sum  = sum + term;
            term = sq30(term, x) / 64'd210;
            sum  = (sum >= term) ? sum - term : 64'd0;
            v    = (sum + 64'd8192) >> 14;
            if (v > 64'd65536) begin
                v = 64'd65536;
            end
            tab[k] = v[16:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    // Phase increment from the low 24 bits of a Q8.24 product.
    function automatic logic [PHASE_BITS-1:0] step_of(logic [23:0] frac);
        logic [23+STEP_SHL:0] wide;
        wide = (24 + STEP_SHL)'(frac) << STEP_SHL;
        return PHASE_BITS'(wide >> STEP_SHR);
    endfunction

    // Signed sine of a phase through the quarter-wave table.
    function automatic t_wave sine_of(logic [PHASE_BITS-1:0] p);
        logic [1:0]             q;
        logic [QR_W-1:0]        r;
        logic [QR_W+SIDX_W-1:0] scaled;
        logic [SIDX_W-1:0]      idx;
        t_wave                  w;
        q      = p[PHASE_BITS-1 -: 2];
        r      = p[QR_W-1:0];
        scaled = (QR_W + SIDX_W)'(r) * (QR_W + SIDX_W)'(SINE_TABLE_DEPTH);
        idx    = SIDX_W'(scaled >> QR_W);
        if (q[0]) begin
            idx = SIDX_W'(SINE_TABLE_DEPTH) - idx;
        end
        w.mag = SINE_TAB[idx];
        w.neg = q[1];
        return w;
    endfunction

    // Triangle wave running from -1 up to +1 and back over one turn.
    function automatic t_wave triangle_of(logic [PHASE_BITS-1:0] p);
        logic [PHASE_BITS+17:0] sh;
        logic [17:0]            f;
        t_wave                  w;
        sh = {p, 18'b0} >> PHASE_BITS;
        f  = sh[17:0];
        if (!p[PHASE_BITS-1]) begin
            if (f < 18'd65536) begin
                w.neg = 1'b1;
                w.mag = 17'(18'd65536 - f);
            end else begin
                w.neg = 1'b0;
                w.mag = 17'(f - 18'd65536);
            end
        end else begin
            if (f <= 18'd196608) begin
                w.neg = 1'b0;
                w.mag = 17'(18'd196608 - f);
            end else begin
                w.neg = 1'b1;
                w.mag = 17'(f - 18'd196608);
            end
        end
        return w;
    endfunction

    // Clamp a wide sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(logic signed [33:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7fffffff;
        end
        if (v < SAT_MIN) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### rtl/wmog_front.sv
// Front end of the waveform motion offset generator: takes tick requests and tags
// each with its pattern class. Depends on wmog_pkg; feeds wmog_queue.
module wmog_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wmog_pkg::t_in_item i_in_item,
    input  wmog_pkg::t_cfg     i_cfg,
    input  logic               i_q_full,
    output wmog_pkg::t_q_wr    o_q_wr
);

    logic               r_valid;
    logic               n_valid;
    wmog_pkg::t_q_entry r_entry;
    wmog_pkg::t_pat     pat;
    logic               accept;
    logic               push;

    // Map the mode register onto a pattern class; unused codes move nothing.
    always_comb begin
        unique case (i_cfg.pattern_mode)
            wmog_pkg::PAT_SINE:   pat = wmog_pkg::PAT_SINE;
            wmog_pkg::PAT_ZIGZAG: pat = wmog_pkg::PAT_ZIGZAG;
            wmog_pkg::PAT_DIVE:   pat = wmog_pkg::PAT_DIVE;
            wmog_pkg::PAT_CIRCLE: pat = wmog_pkg::PAT_CIRCLE;
            default:              pat = wmog_pkg::PAT_LINEAR;
        endcase
    end

    // One holding register; it stalls only while the queue is full.
    assign push       = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_valid    = accept || (r_valid && !push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.item <= i_in_item;
            r_entry.pat  <= pat;
        end
    end

    assign o_q_wr.push  = push;
    assign o_q_wr.entry = r_entry;

endmodule

### rtl/wmog_queue.sv
// Short request queue between the front and back of the waveform motion offset
// generator. Depends on wmog_pkg for the entry type and depth.
module wmog_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wmog_pkg::t_q_wr i_wr,
    output logic            o_full,
    input  logic            i_pop,
    output wmog_pkg::t_q_rd o_rd
);

    wmog_pkg::t_q_entry                  r_mem [wmog_pkg::QUEUE_DEPTH];
    logic [wmog_pkg::QPTR_W-1:0]         r_wptr;
    logic [wmog_pkg::QPTR_W-1:0]         r_rptr;
    logic [wmog_pkg::QCNT_W-1:0]         r_count;
    logic [wmog_pkg::QPTR_W-1:0]         n_wptr;
    logic [wmog_pkg::QPTR_W-1:0]         n_rptr;
    logic [wmog_pkg::QCNT_W-1:0]         n_count;
    logic                                do_push;
    logic                                do_pop;

    assign o_full   = (r_count == wmog_pkg::QCNT_W'(wmog_pkg::QUEUE_DEPTH));
    assign do_push  = i_wr.push && !o_full;
    assign do_pop   = i_pop && (r_count != '0);
    assign o_rd.valid = (r_count != '0);
    assign o_rd.entry = r_mem[r_rptr];

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == wmog_pkg::QPTR_W'(wmog_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == wmog_pkg::QPTR_W'(wmog_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wr.entry;
        end
    end

endmodule

### rtl/wmog_back.sv
// Back end of the waveform motion offset generator: a sequencer that advances both
// accumulators, forms the offsets through one shared multiplier and drives the result
// register. Depends on wmog_pkg; reads wmog_queue.
module wmog_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wmog_pkg::t_cfg      i_cfg,
    input  wmog_pkg::t_q_rd     i_q_rd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wmog_pkg::t_out_item o_out_item
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MPH  = 9'b000000010,
        ST_MDV  = 9'b000000100,
        ST_ADV  = 9'b000001000,
        ST_WAVE = 9'b000010000,
        ST_MAMP = 9'b000100000,
        ST_MSCL = 9'b001000000,
        ST_RND  = 9'b010000000,
        ST_DONE = 9'b100000000
    } t_state;

    localparam int PB = wmog_pkg::PHASE_BITS;

    t_state                  r_state, n_state;
    logic                    r_axis_x, n_axis_x;
    logic [15:0]             r_dt, n_dt;
    wmog_pkg::t_pat          r_pat, n_pat;
    logic signed [32:0]      r_base_x, n_base_x;
    logic signed [32:0]      r_base_y, n_base_y;
    logic [49:0]             r_prod, n_prod;
    logic [PB-1:0]           r_phase, n_phase;
    logic [PB-1:0]           r_dive, n_dive;
    logic [16:0]             r_mag, n_mag;
    logic                    r_neg, n_neg;
    logic signed [31:0]      r_off_x, n_off_x;
    logic signed [31:0]      r_off_y, n_off_y;
    logic signed [31:0]      r_last_x, n_last_x;
    logic signed [31:0]      r_last_y, n_last_y;
    logic                    r_out_valid, n_out_valid;
    wmog_pkg::t_out_item     r_out, n_out;

    logic [32:0]             mul_a;
    logic [16:0]             mul_b;
    logic [49:0]             mul_p;
    logic [15:0]             dfreq;
    logic [16:0]             scale;
    logic [PB-1:0]           fold;
    wmog_pkg::t_wave         wave;
    logic [49:0]             rounded;
    logic signed [31:0]      off_mag;
    logic signed [31:0]      off_val;
    logic                    out_free;

    assign dfreq = (i_cfg.wave_frequency < wmog_pkg::DIVE_MIN_FREQ) ? wmog_pkg::DIVE_MIN_FREQ
                                                                    : i_cfg.wave_frequency;
    assign scale = (r_pat == wmog_pkg::PAT_CIRCLE) ? wmog_pkg::CIRCLE_SCALE
                                                   : wmog_pkg::UNIT_SCALE;
    assign fold  = r_dive[PB-1] ? PB'(0) - r_dive : r_dive;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MPH: begin
                mul_a = 33'(i_cfg.wave_frequency);
                mul_b = 17'(r_dt);
            end
            ST_MDV: begin
                mul_a = 33'(dfreq);
                mul_b = 17'(r_dt);
            end
            ST_MAMP: begin
                mul_a = 33'(i_cfg.wave_amplitude);
                mul_b = r_mag;
            end
            ST_MSCL: begin
                mul_a = r_prod[32:0];
                mul_b = scale;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 50'(mul_a) * 50'(mul_b);

    // Waveform sample for the axis being worked on.
    always_comb begin
        wave.neg = 1'b0;
        wave.mag = '0;
        if (r_axis_x) begin
            wave = wmog_pkg::sine_of(r_phase + wmog_pkg::QUARTER_TURN);
        end else begin
            unique case (r_pat)
                wmog_pkg::PAT_SINE:   wave = wmog_pkg::sine_of(r_phase);
                wmog_pkg::PAT_CIRCLE: wave = wmog_pkg::sine_of(r_phase);
                wmog_pkg::PAT_ZIGZAG: wave = wmog_pkg::triangle_of(r_phase);
                wmog_pkg::PAT_DIVE:   wave = wmog_pkg::sine_of(fold);
                default: begin
                    wave.neg = 1'b0;
                    wave.mag = '0;
                end
            endcase
        end
    end

    // Round the scaled product back to position units and apply the sign.
    assign rounded = r_prod + 50'(1 << 23);
    assign off_mag = signed'(32'(rounded[49:24]));
    assign off_val = r_neg ? -off_mag : off_mag;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) && i_q_rd.valid;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_axis_x    = r_axis_x;
        n_dt        = r_dt;
        n_pat       = r_pat;
        n_base_x    = r_base_x;
        n_base_y    = r_base_y;
        n_prod      = r_prod;
        n_phase     = r_phase;
        n_dive      = r_dive;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_off_x     = r_off_x;
        n_off_y     = r_off_y;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_rd.valid) begin
                    n_dt     = i_q_rd.entry.item.tick_time;
                    n_pat    = i_q_rd.entry.pat;
                    n_base_x = {i_q_rd.entry.item.pos_x_in[31], i_q_rd.entry.item.pos_x_in}
                             - {r_last_x[31], r_last_x};
                    n_base_y = {i_q_rd.entry.item.pos_y_in[31], i_q_rd.entry.item.pos_y_in}
                             - {r_last_y[31], r_last_y};
                    n_axis_x = 1'b0;
                    n_off_x  = '0;
                    n_state  = ST_MPH;
                end
            end
            ST_MPH: begin
                n_prod  = mul_p;
                n_state = ST_MDV;
            end
            ST_MDV: begin
                n_phase = r_phase + wmog_pkg::step_of(r_prod[23:0]);
                n_prod  = mul_p;
                n_state = ST_ADV;
            end
            ST_ADV: begin
                n_dive  = r_dive + wmog_pkg::step_of(r_prod[23:0]);
                n_state = ST_WAVE;
            end
            ST_WAVE: begin
                n_mag   = wave.mag;
                n_neg   = wave.neg;
                n_state = ST_MAMP;
            end
            ST_MAMP: begin
                n_prod  = mul_p;
                n_state = ST_MSCL;
            end
            ST_MSCL: begin
                n_prod  = mul_p;
                n_state = ST_RND;
            end
            ST_RND: begin
                if (r_axis_x) begin
                    n_off_x = off_val;
                    n_state = ST_DONE;
                end else begin
                    n_off_y = off_val;
                    if (r_pat == wmog_pkg::PAT_CIRCLE) begin
                        n_axis_x = 1'b1;
                        n_state  = ST_WAVE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out.pos_x_out = wmog_pkg::sat32({r_base_x[32], r_base_x}
                                                      + 34'(r_off_x));
                    n_out.pos_y_out = wmog_pkg::sat32({r_base_y[32], r_base_y}
                                                      + 34'(r_off_y));
                    n_out.anchor_y  = wmog_pkg::sat32({r_base_y[32], r_base_y});
                    n_out_valid     = 1'b1;
                    n_last_x        = r_off_x;
                    n_last_y        = r_off_y;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_dive      <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_dive      <= n_dive;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge i_clk) begin
        r_axis_x <= n_axis_x;
        r_dt     <= n_dt;
        r_pat    <= n_pat;
        r_base_x <= n_base_x;
        r_base_y <= n_base_y;
        r_prod   <= n_prod;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_off_x  <= n_off_x;
        r_off_y  <= n_off_y;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/waveform_motion_offset_generator.sv
// Top level of the waveform motion offset generator: configuration registers, front end,
// request queue, back-end sequencer. Depends on wmog_pkg, wmog_front, wmog_queue, wmog_back.
//
// Each tick request carries a time step and the entity's current position. The block
// answers with the new position and the vertical baseline. The back-end sequencer
// runs every product through one shared 33 x 17 multiplier: both phase steps, then
// amplitude and scale for the vertical axis and, in circle mode, the horizontal one.
// The back end takes a new tick off the queue only once it has passed its last result
// to the result register, and it waits while that register is stalled. The front
// holding register and a two-entry queue take up to three further ticks while the back
// end works or its result waits. The input side sees a stall only when all of them are
// full. Configuration writes are expected while no tick is in flight.
module waveform_motion_offset_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  wmog_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output wmog_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [wmog_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wmog_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    wmog_pkg::t_cfg  r_cfg;
    wmog_pkg::t_q_wr q_wr;
    wmog_pkg::t_q_rd q_rd;
    logic            q_full;
    logic            q_pop;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_mode   <= wmog_pkg::PAT_LINEAR;
            r_cfg.wave_frequency <= wmog_pkg::FREQ_RESET;
            r_cfg.wave_amplitude <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wmog_pkg::REG_MODE: r_cfg.pattern_mode   <= i_cfg_data[2:0];
                wmog_pkg::REG_FREQ: r_cfg.wave_frequency <= i_cfg_data;
                wmog_pkg::REG_AMP:  r_cfg.wave_amplitude <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    wmog_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr)
    );

    wmog_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    wmog_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_rd      (q_rd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### rtl/wmog_checker.sv
// Port-level assertions for the waveform motion offset generator, bound to the top level.
// Depends on wmog_pkg for the result type.
module wmog_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input wmog_pkg::t_out_item o_out_item
);

    localparam logic signed [32:0] OFF_LIMIT = 33'sd16777216;

    logic signed [32:0] diff_y;
    logic               unsat_y;

    // Offset seen between the moved position and the baseline.
    assign diff_y  = {o_out_item.pos_y_out[31], o_out_item.pos_y_out}
                   - {o_out_item.anchor_y[31], o_out_item.anchor_y};
    assign unsat_y = (o_out_item.pos_y_out != 32'sh7fffffff)
                  && (o_out_item.pos_y_out != 32'sh80000000)
                  && (o_out_item.anchor_y != 32'sh7fffffff)
                  && (o_out_item.anchor_y != 32'sh80000000);

    // A stalled result request stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result request dropped while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("result payload changed while stalled");

    // No result is offered straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid ##1 !o_out_valid)
        else $error("result offered too soon after reset");

    // Without saturation the vertical offset stays within the amplitude range.
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && unsat_y) |-> (diff_y <= OFF_LIMIT && diff_y >= -OFF_LIMIT))
        else $error("vertical offset out of range");

endmodule

bind waveform_motion_offset_generator wmog_checker u_wmog_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

### dv/tb_top.sv
// Testbench of the waveform motion offset generator: random and corner ticks under
// random request gaps and result stalls, checked against an in-bench oscillator model.
// Depends on wmog_pkg and the waveform_motion_offset_generator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [wmog_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_TICKS = 1450;
    localparam int CALM_TICKS = 150;

    // Tracks the oscillator and position state, and keeps the positions still owed.
    class motion_tracker;
        logic [2:0]          mode;
        logic [15:0]         freq;
        logic [15:0]         amp;
        logic [15:0]         phase;
        logic [15:0]         dive_cyc;
        logic signed [31:0]  prev_ox;
        logic signed [31:0]  prev_oy;
        logic [16:0]         quarter_wave [0:wmog_pkg::SINE_TABLE_DEPTH];
        wmog_pkg::t_out_item awaited[$];
        wmog_pkg::t_out_item last_pred;
        int                  errors;

        function new();
            logic [63:0] x;
            logic [63:0] term;
            logic [63:0] sum;
            logic [63:0] v;
            // Quarter-wave table from a truncated Taylor series in Q30.
            for (int k = 0; k <= wmog_pkg::SINE_TABLE_DEPTH; k++) begin
                x    = (64'(k) * wmog_pkg::HALF_PI_Q30) / 64'(wmog_pkg::SINE_TABLE_DEPTH);
                term = x;
                sum  = x;
                for (int n = 1; n <= 7; n++) begin
                    term = (term * x) >> 30;
                    term = (term * x) >> 30;
                    term = term / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        sum = (sum >= term) ? sum - term : 64'd0;
                    end else begin
                        sum = sum + term;
                    end
                end
                v = (sum + 64'd8192) >> 14;
                if (v > 64'd65536) begin
                    v = 64'd65536;
                end
                quarter_wave[k] = v[16:0];
            end
            mode      = wmog_pkg::PAT_LINEAR;
            freq      = wmog_pkg::FREQ_RESET;
            amp       = 16'd0;
            phase     = 16'd0;
            dive_cyc  = 16'd0;
            prev_ox   = 32'sd0;
            prev_oy   = 32'sd0;
            last_pred = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [wmog_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                wmog_pkg::REG_MODE: mode = data[2:0];
                wmog_pkg::REG_FREQ: freq = data;
                wmog_pkg::REG_AMP:  amp  = data;
                default:  ;
            endcase
        endfunction

        // Fraction bits of frequency times time step, as a phase increment.
        function logic [15:0] phase_step(logic [15:0] f, logic [15:0] dt);
            logic [31:0] prod;
            prod = 32'(f) * 32'(dt);
            return prod[23:8];
        endfunction

        function longint sine_val(logic [15:0] p);
            longint idx;
            idx = (longint'(p[wmog_pkg::QR_W-1:0]) * wmog_pkg::SINE_TABLE_DEPTH)
                  >> wmog_pkg::QR_W;
            if (p[14]) begin
                idx = wmog_pkg::SINE_TABLE_DEPTH - idx;
            end
            return p[15] ? -longint'(quarter_wave[idx]) : longint'(quarter_wave[idx]);
        endfunction

        function longint triangle_val(logic [15:0] p);
            longint f;
            f = longint'(p) * 4;
            return p[15] ? 196608 - f : f - 65536;
        endfunction

        function logic signed [31:0] offset_of(longint w, longint scale);
            longint mag;
            longint v;
            mag = (w < 0) ? -w : w;
            v   = (longint'(amp) * mag * scale + 64'sd8388608) >>> 24;
            return (w < 0) ? 32'(-v) : 32'(v);
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) begin
                return 32'sh7fffffff;
            end
            if (v < -64'sd2147483648) begin
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        // Advances the oscillator by one accepted tick request and queues its position.
        function void note_tick(wmog_pkg::t_in_item it);
            logic [15:0]         dive_freq;
            logic [15:0]         folded;
            logic signed [31:0]  ox;
            logic signed [31:0]  oy;
            longint              bx;
            longint              by;
            wmog_pkg::t_out_item e;
            dive_freq = (freq < wmog_pkg::DIVE_MIN_FREQ) ? wmog_pkg::DIVE_MIN_FREQ : freq;
            phase     = phase + phase_step(freq, it.tick_time);
            dive_cyc  = dive_cyc + phase_step(dive_freq, it.tick_time);
            bx = longint'($signed(it.pos_x_in)) - longint'(prev_ox);
            by = longint'($signed(it.pos_y_in)) - longint'(prev_oy);
            ox = 32'sd0;
            oy = 32'sd0;
            case (mode)
                wmog_pkg::PAT_SINE: begin
                    oy = offset_of(sine_val(phase), longint'(wmog_pkg::UNIT_SCALE));
                end
                wmog_pkg::PAT_ZIGZAG: begin
                    oy = offset_of(triangle_val(phase), longint'(wmog_pkg::UNIT_SCALE));
                end
                wmog_pkg::PAT_DIVE: begin
                    // The dive cycle folds back over its second half.
                    folded = dive_cyc[15] ? 16'd0 - dive_cyc : dive_cyc;
                    oy = offset_of(sine_val(folded), longint'(wmog_pkg::UNIT_SCALE));
                end
                wmog_pkg::PAT_CIRCLE: begin
                    ox = offset_of(sine_val(phase + wmog_pkg::QUARTER_TURN),
                                   longint'(wmog_pkg::CIRCLE_SCALE));
                    oy = offset_of(sine_val(phase), longint'(wmog_pkg::CIRCLE_SCALE));
                end
                default: ;
            endcase
            e.pos_x_out = clamp32(bx + longint'(ox));
            e.pos_y_out = clamp32(by + longint'(oy));
            e.anchor_y  = clamp32(by);
            prev_ox   = ox;
            prev_oy   = oy;
            last_pred = e;
            awaited.push_back(e);
        endfunction

        function void check_result(wmog_pkg::t_out_item got);
            wmog_pkg::t_out_item want;
            if (awaited.size() == 0) begin
                $display("%0t: position %h with no tick request waiting", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.pos_x_out !== want.pos_x_out) begin
                $display("%0t: pos_x_out expected %0d actual %0d",
                         $time, want.pos_x_out, got.pos_x_out);
                errors++;
            end
            if (got.pos_y_out !== want.pos_y_out) begin
                $display("%0t: pos_y_out expected %0d actual %0d",
                         $time, want.pos_y_out, got.pos_y_out);
                errors++;
            end
            if (got.anchor_y !== want.anchor_y) begin
                $display("%0t: anchor_y expected %0d actual %0d",
                         $time, want.anchor_y, got.anchor_y);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            tick_valid = 1'b0;
    logic                            tick_stall;
    wmog_pkg::t_in_item              tick_req = '0;
    logic                            pos_valid;
    logic                            pos_stall = 1'b0;
    wmog_pkg::t_out_item             pos_rsp;
    logic                            cfg_we = 1'b0;
    logic [wmog_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [wmog_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            gaps_on = 1'b1;
    int                              stall_left = 0;
    int                              quiet_cycles = 0;
    motion_tracker                   tracker = new();

    waveform_motion_offset_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tick_valid),
        .o_in_stall  (tick_stall),
        .i_in_item   (tick_req),
        .o_out_valid (pos_valid),
        .i_out_stall (pos_stall),
        .o_out_item  (pos_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Result stalls come in bursts while gaps are enabled.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14);
        end
        pos_stall <= (stall_left > 0);
    end

    // Every accepted position is checked against the oldest one owed.
    always @(posedge clk) begin
        if (rst_n && pos_valid && !pos_stall) begin
            tracker.check_result(pos_rsp);
        end
    end

    // Ends a run in which no request moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (tick_valid && !tick_stall) || (pos_valid && !pos_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[waveform_motion_offset_generator] ERROR");
            $finish;
        end
    end

    // Offers one tick request from a falling edge and returns at the falling edge
    // after it is accepted; valid stays high for a back-to-back request.
    task automatic send_tick(input wmog_pkg::t_in_item it);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick_req   <= it;
        do begin
            @(posedge clk);
        end while (tick_stall);
        tracker.note_tick(it);
        @(negedge clk);
    endtask

    // Stops requests and waits until every position owed has come back.
    task automatic drain();
        tick_valid <= 1'b0;
        while (tracker.awaited.size() != 0) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [wmog_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.set_reg(idx, data);
        @(negedge clk);
    endtask

    initial begin
        wmog_pkg::t_in_item it;
        int                 sent;
        int                 phase_len;
        int                 r;
        logic [15:0]        f;
        logic [15:0]        a;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Corner ticks in every mode code, the reset settings first.
        for (int m = 0; m < 8; m++) begin
            if (m == 1) begin
                write_reg(REG_UNUSED, 16'hffff);
            end
            if (m > 0) begin
                write_reg(wmog_pkg::REG_MODE, 16'(m));
                // Dive at zero frequency exercises the rate floor.
                f = (m == 3) ? 16'd0 : ((m == 4 || m == 5) ? 16'hffff : 16'(300 * m));
                write_reg(wmog_pkg::REG_FREQ, f);
                write_reg(wmog_pkg::REG_AMP, (m == 6) ? 16'd0 : 16'hffff);
            end
            for (int k = 0; k < 3; k++) begin
                it.tick_time = (k == 0) ? 16'd0 : ((k == 1) ? 16'hffff : 16'($urandom));
                it.pos_x_in  = (k == 0) ? 32'sh7fffffff : ((k == 1) ? 32'sh80000000 : $urandom);
                it.pos_y_in  = (k == 0) ? 32'sh80000000 : ((k == 1) ? 32'sh7fffffff : 32'sd0);
                send_tick(it);
            end
            drain();
        end

        // Random phases: fresh settings, then mostly a game loop that feeds each
        // predicted position back in, with some noise and extreme positions.
        sent = 0;
        while (sent < RANDOM_TICKS) begin
            r = $urandom_range(0, 11);
            write_reg(wmog_pkg::REG_MODE, 16'((r < 8) ? r : r - 7));
            case ($urandom_range(0, 5))
                0:       f = 16'd0;
                1:       f = 16'hffff;
                2:       f = 16'($urandom_range(1, 63));
                3:       f = 16'($urandom_range(64, 2048));
                default: f = 16'($urandom);
            endcase
            write_reg(wmog_pkg::REG_FREQ, f);
            case ($urandom_range(0, 4))
                0:       a = 16'd0;
                1:       a = 16'hffff;
                2:       a = 16'($urandom_range(16, 4096));
                default: a = 16'($urandom);
            endcase
            write_reg(wmog_pkg::REG_AMP, a);
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_UNUSED, 16'($urandom));
            end
            if (sent >= RANDOM_TICKS - CALM_TICKS) begin
                gaps_on = 1'b0;
            end
            phase_len = $urandom_range(20, 80);
            for (int k = 0; k < phase_len && sent < RANDOM_TICKS; k++) begin
                case ($urandom_range(0, 9))
                    0:       it.tick_time = 16'd0;
                    1:       it.tick_time = 16'hffff;
                    2, 3:    it.tick_time = 16'($urandom);
                    default: it.tick_time = 16'($urandom_range(200, 2200));
                endcase
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    it.pos_x_in = tracker.last_pred.pos_x_out + $urandom_range(0, 8191) - 4096;
                    it.pos_y_in = tracker.last_pred.pos_y_out + $urandom_range(0, 8191) - 4096;
                end else if (r < 9) begin
                    it.pos_x_in = $urandom;
                    it.pos_y_in = $urandom;
                end else begin
                    it.pos_x_in = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                    it.pos_y_in = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                end
                send_tick(it);
                sent++;
            end
            drain();
        end

        repeat (32) @(posedge clk);
        if (tracker.errors == 0) begin
            $display("[waveform_motion_offset_generator] OK");
        end else begin
            $display("[waveform_motion_offset_generator] ERROR");
        end
        $finish;
    end

endmodule
